/* sv/ss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ss_pkg: shared types and constants for the substring search block
// Sizes, item opcodes, result status codes and the cell chain control group.
// ----------------------------------------------------------------------------
package ss_pkg;

    localparam int MAX_PATTERN   = 32;
    localparam int POSITION_BITS = 16;
    localparam int PCOUNT_W      = $clog2(MAX_PATTERN + 1);

    typedef logic [7:0]               t_byte;
    typedef logic [PCOUNT_W-1:0]      t_pcount;
    typedef logic [POSITION_BITS-1:0] t_pos;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TEXT   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_SAT      = 2'd3
    } t_status;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic pat_shift;   // append: pattern bytes move one cell up
        logic pat_clear;   // clear: all cells become unused
        logic txt_shift;   // text byte: window moves one cell up
    } t_chain_ctl;

endpackage

/* sv/ss_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ss_cell: one compare cell
// Holds one pattern byte, its in-use flag and one window byte; compares the
// window byte arriving from the lower neighbor against the pattern byte.
// ----------------------------------------------------------------------------
module ss_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ss_pkg::t_chain_ctl i_ctl,
    input  ss_pkg::t_byte     i_pat,
    input  logic              i_occ,
    input  ss_pkg::t_byte     i_win,
    output ss_pkg::t_byte     o_pat,
    output logic              o_occ,
    output ss_pkg::t_byte     o_win,
    output logic              o_eq
);
    import ss_pkg::*;

    t_byte r_pat;
    t_byte r_win;
    logic  r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.pat_clear) begin
            r_occ <= 1'b0;
        end else if (i_ctl.pat_shift) begin
            r_occ <= i_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_shift) begin
            r_pat <= i_pat;
        end
        if (i_ctl.txt_shift) begin
            r_win <= i_win;
        end
    end

    // unused cells never block a match
    assign o_eq  = !r_occ || (i_win == r_pat);
    assign o_pat = r_pat;
    assign o_occ = r_occ;
    assign o_win = r_win;

endmodule

/* sv/ss_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ss_chain: row of compare cells
// Cell k pairs the pattern byte appended k items ago with the text byte
// seen k bytes ago; the match flag is the AND of all cell compares.
// ----------------------------------------------------------------------------
module ss_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ss_pkg::t_chain_ctl i_ctl,
    input  ss_pkg::t_byte      i_byte,
    output logic               o_match
);
    import ss_pkg::*;

    t_byte                  pat_link [MAX_PATTERN+1];
    t_byte                  win_link [MAX_PATTERN+1];
    logic [MAX_PATTERN:0]   occ_link;
    logic [MAX_PATTERN-1:0] eq;

    assign pat_link[0] = i_byte;
    assign win_link[0] = i_byte;
    assign occ_link[0] = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        ss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_pat   (pat_link[k]),
            .i_occ   (occ_link[k]),
            .i_win   (win_link[k]),
            .o_pat   (pat_link[k+1]),
            .o_occ   (occ_link[k+1]),
            .o_win   (win_link[k+1]),
            .o_eq    (eq[k])
        );
    end

    assign o_match = &eq;

endmodule

/* sv/substring_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search: streaming first-occurrence pattern search
// Pattern is loaded byte by byte into a chain of compare cells, text streams
// through the same chain, and one result item follows each last text byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one item per accepted edge. op selects
//   append pattern byte, text byte or clear pattern; end_of_text on a text
//   byte closes the search. Appending or clearing abandons a running search.
//   Output channel (o_valid / i_stall): one result item per last text byte,
//   held in an output register: found, match_start, match_length,
//   text_length and status.
//   Throughput: one item per cycle while o_stall is low. Each text byte is
//   compared against the whole pattern in the cycle it is taken, by the 32-cell chain.
//   Latency: the result is valid the cycle after the last text byte is taken.
//   Stall: while a result waits and i_stall is high, o_stall is high and no
//   item is taken; a waiting result is replaced in the same edge it leaves.
//   Config: i_cfg_wr_en writes anchored mode (prefix-only matching); write
//   it only while the block is idle.
//   Reset (i_rst_n low, synchronous): pattern empty, search state cleared,
//   anchored mode off, no result pending.
// ----------------------------------------------------------------------------
module substring_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_op,
    input  ss_pkg::t_byte        i_data_byte,
    input  logic                 i_end_of_text,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_found,
    output ss_pkg::t_pos         o_match_start,
    output logic [5:0]           o_match_length,
    output ss_pkg::t_pos         o_text_length,
    output logic [1:0]           o_status
);
    import ss_pkg::*;

    localparam t_pos POS_LIMIT = '1;

    // control / search state
    logic    r_anchored;
    t_pcount r_pcount, n_pcount;
    logic    r_ovf, n_ovf;
    t_pos    r_cnt, n_cnt;
    logic    r_sat, n_sat;
    logic    r_hit, n_hit;
    t_pos    r_hitpos, n_hitpos;
    logic    r_out_valid, n_out_valid;

    // result register
    logic    r_found, n_found;
    t_pos    r_start, n_start;
    t_pcount r_len, n_len;
    t_pos    r_tlen, n_tlen;
    t_status r_status, n_status;

    logic       acc;
    t_chain_ctl ctl;
    logic       match;
    t_pos       cnt_inc;
    t_pos       p_ext;
    t_pos       s_pos;
    logic       sat_now;

    assign o_stall = r_out_valid && i_stall;
    assign acc     = i_valid && !o_stall;

    // pattern bytes shift in only while there is room; a full append overflows
    always_comb begin
        ctl.pat_shift = acc && (i_op == OP_APPEND) && (r_pcount != t_pcount'(MAX_PATTERN));
        ctl.pat_clear = acc && (i_op == OP_CLEAR);
        ctl.txt_shift = acc && (i_op == OP_TEXT) && (r_cnt != POS_LIMIT);
    end

    ss_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_byte  (i_data_byte),
        .o_match (match)
    );

    assign sat_now = (r_cnt == POS_LIMIT);
    assign cnt_inc = r_cnt + 1'b1;
    assign p_ext   = t_pos'(r_pcount);
    assign s_pos   = cnt_inc - p_ext;

    always_comb begin
        n_pcount    = r_pcount;
        n_ovf       = r_ovf;
        n_cnt       = r_cnt;
        n_sat       = r_sat;
        n_hit       = r_hit;
        n_hitpos    = r_hitpos;
        n_out_valid = r_out_valid && i_stall;
        n_found     = r_found;
        n_start     = r_start;
        n_len       = r_len;
        n_tlen      = r_tlen;
        n_status    = r_status;

        if (acc) begin
            case (i_op)
                OP_APPEND: begin
                    if (r_pcount == t_pcount'(MAX_PATTERN)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_pcount = r_pcount + 1'b1;
                    end
                    n_cnt    = '0;
                    n_sat    = 1'b0;
                    n_hit    = 1'b0;
                    n_hitpos = '0;
                end
                OP_CLEAR: begin
                    n_pcount = '0;
                    n_ovf    = 1'b0;
                    n_cnt    = '0;
                    n_sat    = 1'b0;
                    n_hit    = 1'b0;
                    n_hitpos = '0;
                end
                OP_TEXT: begin
                    if (sat_now) begin
                        n_sat = 1'b1;
                    end else begin
                        n_cnt = cnt_inc;
                        // new start position complete: test it once
                        if (!r_hit && (r_pcount != '0) && (cnt_inc >= p_ext)
                            && (!r_anchored || (s_pos == '0)) && match) begin
                            n_hit    = 1'b1;
                            n_hitpos = s_pos;
                        end
                    end

                    if (i_end_of_text) begin
                        if (r_ovf) begin
                            n_status = ST_OVERFLOW;
                        end else if (n_sat) begin
                            n_status = ST_SAT;
                        end else if (p_ext > n_cnt) begin
                            n_status = ST_SHORT;
                        end else begin
                            n_status = ST_OK;
                        end

                        if ((n_status == ST_SHORT) || (n_status == ST_OVERFLOW)) begin
                            n_found = 1'b0;
                            n_start = '0;
                        end else if (r_pcount == '0) begin
                            // empty pattern matches at the text start
                            n_found = 1'b1;
                            n_start = '0;
                        end else begin
                            n_found = n_hit;
                            n_start = n_hit ? n_hitpos : '0;
                        end
                        n_len       = r_pcount;
                        n_tlen      = n_cnt;
                        n_out_valid = 1'b1;

                        n_cnt    = '0;
                        n_sat    = 1'b0;
                        n_hit    = 1'b0;
                        n_hitpos = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchored  <= 1'b0;
            r_pcount    <= '0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
            r_hit       <= 1'b0;
            r_hitpos    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_anchored <= i_cfg_wr_data;
            end
            r_pcount    <= n_pcount;
            r_ovf       <= n_ovf;
            r_cnt       <= n_cnt;
            r_sat       <= n_sat;
            r_hit       <= n_hit;
            r_hitpos    <= n_hitpos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found  <= n_found;
        r_start  <= n_start;
        r_len    <= n_len;
        r_tlen   <= n_tlen;
        r_status <= n_status;
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_match_start  = r_start;
    assign o_match_length = 6'(r_len);
    assign o_text_length  = r_tlen;
    assign o_status       = r_status;

`ifndef ASSERT_OFF
    a_pcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= t_pcount'(MAX_PATTERN))
        else $error("pattern count past capacity");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (o_status == ST_OK) || (o_status == ST_SAT))
        else $error("found reported with failing status");

    a_ok_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_OK) && o_found
        |-> (32'(o_match_start) + 32'(o_match_length)) <= 32'(o_text_length))
        else $error("match runs past end of text");

    a_anchored_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_anchored && r_hit |-> r_hitpos == '0)
        else $error("anchored hit away from text start");
`endif

endmodule

/* tb/substring_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_checker: search result predictor and comparator
// Follows every accepted item and register write, keeps its own copy of the
// pattern and text window, and checks each result item field by field.
// ----------------------------------------------------------------------------
module substring_search_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 i_valid,
    input  logic                 i_stall,
    input  logic [1:0]           i_op,
    input  ss_pkg::t_byte        i_data_byte,
    input  logic                 i_end_of_text,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic                 i_found,
    input  ss_pkg::t_pos         i_match_start,
    input  logic [5:0]           i_match_length,
    input  ss_pkg::t_pos         i_text_length,
    input  logic [1:0]           i_status,
    output int                   o_fail_count,
    output int                   o_pending
);
    import ss_pkg::*;

    typedef struct packed {
        logic       found;
        t_pos       start;
        logic [5:0] pat_len;
        t_pos       txt_len;
        logic [1:0] status;
    } t_search_report;

    t_byte          pat_mem [MAX_PATTERN];
    t_pcount        pat_len;
    logic           pat_over;
    t_byte          win [MAX_PATTERN];
    t_pos           txt_cnt;
    logic           txt_sat;
    logic           hit;
    t_pos           hit_pos;
    logic           anchored;
    t_search_report report_q [$];
    int             mismatches;

    task automatic restart_search();
        for (int k = 0; k < MAX_PATTERN; k++) win[k] = '0;
        txt_cnt = '0;
        txt_sat = 1'b0;
        hit     = 1'b0;
        hit_pos = '0;
    endtask

    // newest byte sits in win[0]; pattern byte k pairs with win[p-1-k]
    function automatic logic window_hit(input t_pcount p);
        for (int k = 0; k < int'(p); k++)
            if (win[int'(p) - 1 - k] != pat_mem[k]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic advance_search(input logic [1:0] op, input t_byte b, input logic last);
        t_search_report r;
        t_pos           s;
        case (op)
            OP_APPEND: begin
                if (int'(pat_len) < MAX_PATTERN) begin
                    pat_mem[int'(pat_len)] = b;
                    pat_len = pat_len + 1'b1;
                end else begin
                    pat_over = 1'b1;
                end
                restart_search();
            end
            OP_CLEAR: begin
                pat_len  = '0;
                pat_over = 1'b0;
                restart_search();
            end
            OP_TEXT: begin
                if (txt_cnt == '1) begin
                    txt_sat = 1'b1;
                end else begin
                    for (int k = MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
                    win[0]  = b;
                    txt_cnt = txt_cnt + 1'b1;
                    if (!hit && pat_len != 0 && txt_cnt >= t_pos'(pat_len)) begin
                        s = txt_cnt - t_pos'(pat_len);
                        if ((!anchored || s == 0) && window_hit(pat_len)) begin
                            hit     = 1'b1;
                            hit_pos = s;
                        end
                    end
                end
                if (last) begin
                    r.pat_len = 6'(pat_len);
                    r.txt_len = txt_cnt;
                    // overflow beats saturation beats short text
                    if (pat_over)                          r.status = ST_OVERFLOW;
                    else if (txt_sat)                      r.status = ST_SAT;
                    else if (t_pos'(pat_len) > txt_cnt)    r.status = ST_SHORT;
                    else                                   r.status = ST_OK;
                    if (r.status == ST_SHORT || r.status == ST_OVERFLOW) begin
                        r.found = 1'b0;
                        r.start = '0;
                    end else if (pat_len == 0) begin
                        r.found = 1'b1;
                        r.start = '0;
                    end else begin
                        r.found = hit;
                        r.start = hit ? hit_pos : '0;
                    end
                    report_q.push_back(r);
                    restart_search();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_search_report got;
        t_search_report want;
        if (!i_rst_n) begin
            pat_len  = '0;
            pat_over = 1'b0;
            anchored = 1'b0;
            restart_search();
            report_q.delete();
        end else begin
            // result side first: it always belongs to an earlier item
            if (i_res_valid && !i_res_stall) begin
                got.found   = i_found;
                got.start   = i_match_start;
                got.pat_len = i_match_length;
                got.txt_len = i_text_length;
                got.status  = i_status;
                if (report_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing pending: ", $realtime,
                                 "found=%0d start=%0d len=%0d text=%0d status=%0d",
                                 got.found, got.start, got.pat_len, got.txt_len,
                                 got.status);
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    if (got.found !== want.found || got.start !== want.start ||
                        got.pat_len !== want.pat_len || got.txt_len !== want.txt_len ||
                        got.status !== want.status) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch ", $realtime,
                                     "exp found=%0d start=%0d len=%0d text=%0d status=%0d",
                                     want.found, want.start, want.pat_len,
                                     want.txt_len, want.status,
                                     " got found=%0d start=%0d len=%0d text=%0d status=%0d",
                                     got.found, got.start,
                                     got.pat_len, got.txt_len, got.status);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_wr_en) anchored = i_cfg_wr_data;
            if (i_valid && !i_stall) advance_search(i_op, i_data_byte, i_end_of_text);
        end
        o_fail_count <= mismatches;
        o_pending    <= report_q.size();
    end

endmodule

/* tb/substring_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_tb: stimulus and verdict for the substring search block
// Directed items for the corner cases, then random pattern loads and texts
// in phases of idling and anchored mode; a side checker scores the results.
// ----------------------------------------------------------------------------
module substring_search_tb;
    import ss_pkg::*;

    localparam int         HALF_PERIOD     = 6;       // 12 ns clock
    localparam int         RESET_CYCLES    = 8;
    localparam int         SETTLE_CYCLES   = 4;       // result comes the cycle after the last byte
    localparam int         ITEMS_PER_PHASE = 190;     // 8 phases, about 1500 items
    localparam int         LIMIT_CYCLES    = 600000;
    localparam logic [1:0] OP_UNUSED       = 2'd3;    // selector the block must ignore

    // block inputs, all known from time zero
    logic  i_clk          = 1'b0;
    logic  i_rst_n        = 1'b0;
    logic  i_cfg_wr_en    = 1'b0;
    logic  i_cfg_wr_data  = 1'b0;
    logic  i_valid        = 1'b0;
    logic  o_stall;
    logic  [1:0] i_op     = OP_TEXT;
    t_byte i_data_byte    = '0;
    logic  i_end_of_text  = 1'b0;
    logic  o_valid;
    logic  i_stall        = 1'b0;
    logic  o_found;
    t_pos  o_match_start;
    logic  [5:0] o_match_length;
    t_pos  o_text_length;
    logic  [1:0] o_status;

    int chk_fails;
    int chk_pending;

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int sent_items     = 0;   // items the block acts on (unused selector left out)
    int cycle_cnt      = 0;

    // what the stimulus believes the pattern is, for planting it in text
    t_byte gen_pat [MAX_PATTERN];
    int    gen_len = 0;       // bytes appended since the last clear, may pass 32

    substring_search i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_match_start  (o_match_start),
        .o_match_length (o_match_length),
        .o_text_length  (o_text_length),
        .o_status       (o_status)
    );

    substring_search_checker u_search_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .i_stall        (o_stall),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_end_of_text  (i_end_of_text),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_found        (o_found),
        .i_match_start  (o_match_start),
        .i_match_length (o_match_length),
        .i_text_length  (o_text_length),
        .i_status       (o_status),
        .o_fail_count   (chk_fails),
        .o_pending      (chk_pending)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("substring_search_tb: errors");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk) begin
        i_stall <= (int'($urandom_range(99)) < recv_stall_pct);
    end

    // Drive one item at a falling edge, after a random number of idle cycles,
    // and hold it until a rising edge takes it (valid high, stall low).
    task automatic send_item(input logic [1:0] op, input t_byte b, input logic eot);
        logic placed;
        placed = 1'b0;
        while (!placed) begin
            @(negedge i_clk);
            if (int'($urandom_range(99)) < send_idle_pct) begin
                i_valid <= 1'b0;
            end else begin
                i_valid       <= 1'b1;
                i_op          <= op;
                i_data_byte   <= b;
                i_end_of_text <= eot;
                placed = 1'b1;
            end
        end
        do @(posedge i_clk); while (o_stall);
        if (op != OP_UNUSED) sent_items++;
    endtask

    task automatic append_byte(input t_byte b, input logic eot);
        send_item(OP_APPEND, b, eot);
        if (gen_len < MAX_PATTERN) gen_pat[gen_len] = b;
        gen_len++;
    endtask

    task automatic clear_pattern(input logic eot);
        send_item(OP_CLEAR, t_byte'($urandom_range(255)), eot);
        gen_len = 0;
    endtask

    // Drop valid, then wait until every predicted result has come out and
    // the block has had a few cycles to settle. Ends on a falling edge.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Only called right after drain(), so the block is idle.
    task automatic write_anchored(input logic v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly a three-letter alphabet so accidental and partial matches
    // happen often; the rest spans every byte value.
    function automatic t_byte pick_byte();
        if ($urandom_range(99) < 60) return t_byte'(8'h61 + $urandom_range(2));
        return t_byte'($urandom_range(255));
    endfunction

    // One search: maybe a new pattern, then a text that often carries the
    // pattern at a random spot (or at the start, for the anchored mode).
    // Noise: unused selectors, stray end markers on pattern items, and rare
    // pattern changes in the middle of a text.
    task automatic run_search();
        t_byte txt [72];
        int    n_app;
        int    n_txt;
        int    plen;
        int    at;
        int    roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            if ($urandom_range(99) < 80) clear_pattern(1'($urandom_range(1)));
            roll = $urandom_range(99);
            if (roll < 8)       n_app = 0;
            else if (roll < 78) n_app = $urandom_range(6, 1);
            else if (roll < 90) n_app = $urandom_range(31, 7);
            else if (roll < 95) n_app = MAX_PATTERN;
            else                n_app = $urandom_range(MAX_PATTERN + 2, MAX_PATTERN + 1);
            repeat (n_app) append_byte(pick_byte(), 1'($urandom_range(1)));
        end
        plen = (gen_len > MAX_PATTERN) ? MAX_PATTERN : gen_len;
        // now and then a text shorter than the pattern
        if (plen > 1 && $urandom_range(99) < 10) n_txt = $urandom_range(plen - 1, 1);
        else                                     n_txt = $urandom_range(plen + 16, 1);
        for (int k = 0; k < n_txt; k++) txt[k] = pick_byte();
        if (plen > 0 && plen <= n_txt && $urandom_range(99) < 60) begin
            at = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(n_txt - plen));
            for (int k = 0; k < plen; k++) txt[at + k] = gen_pat[k];
        end
        for (int k = 0; k < n_txt; k++) begin
            if ($urandom_range(99) < 4)
                send_item(OP_UNUSED, t_byte'($urandom_range(255)), 1'($urandom_range(1)));
            if ($urandom_range(999) < 5) begin
                // pattern change abandons the running search
                if ($urandom_range(1) == 0) clear_pattern(1'($urandom_range(1)));
                else                        append_byte(pick_byte(), 1'($urandom_range(1)));
            end
            send_item(OP_TEXT, txt[k], k == n_txt - 1);
        end
    endtask

    initial begin : stimulus
        int phase_start;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed corner cases, no idling ---
        // empty pattern matches at position 0
        send_item(OP_TEXT, 8'h5A, 1'b1);
        // unused selector, even with the end marker, gives nothing
        send_item(OP_UNUSED, 8'hFF, 1'b1);
        // stray end marker on an append is ignored
        append_byte(8'h00, 1'b1);
        append_byte(8'hFF, 1'b0);
        send_item(OP_TEXT, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'hFF, 1'b1);
        send_item(OP_TEXT, 8'h17, 1'b0);
        send_item(OP_TEXT, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'hFF, 1'b1);
        // pattern longer than text
        append_byte(8'h80, 1'b0);
        send_item(OP_TEXT, 8'h00, 1'b1);
        // stray end marker on a clear
        clear_pattern(1'b1);
        // overflow: 33rd byte is dropped and flags status until the next clear
        for (int k = 0; k <= MAX_PATTERN; k++) append_byte(t_byte'(k * 8), 1'b0);
        send_item(OP_TEXT, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'hF8, 1'b1);

        // --- random phases: idling pattern x anchored mode ---
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_anchored(1'((ph >> 2) & 1));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            phase_start = sent_items;
            while (sent_items - phase_start < ITEMS_PER_PHASE) run_search();
        end
        drain();

        if (chk_fails == 0 && chk_pending == 0) begin
            $display("substring_search_tb: clean");
        end else begin
            $display("substring_search_tb: errors");
        end
        $finish;
    end

endmodule

/* substring_search.f */
sv/ss_pkg.sv
sv/ss_cell.sv
sv/ss_chain.sv
sv/substring_search.sv
tb/substring_search_checker.sv
tb/substring_search_tb.sv
